[hdl/lps_pkg.sv]
// Shared constants for the Bresenham line pixel stepper.
`timescale 1ns / 1ps
`default_nettype none

package lps_pkg;

    // Default coordinate width of the block.
    localparam int COORD_BITS_DEF = 12;

    // Entries in the queue between the front and back ends.
    localparam int QUEUE_DEPTH = 2;

    // Command codes carried on the input tuser.
    localparam logic CMD_START = 1'b0;
    localparam logic CMD_STEP  = 1'b1;

endpackage

`default_nettype wire

[hdl/lps_front.sv]
// Front end: decodes input words and prepares the setup for a new line.
`timescale 1ns / 1ps
`default_nettype none

module lps_front
    import lps_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF,
    localparam int ERR_BITS  = COORD_BITS + 3,
    localparam int ITEM_BITS = 3 * COORD_BITS + 3 * ERR_BITS + 3
) (
    input  wire logic                  cmd,
    input  wire logic [COORD_BITS-1:0] x_begin,
    input  wire logic [COORD_BITS-1:0] y_begin,
    input  wire logic [COORD_BITS-1:0] x_end,
    input  wire logic [COORD_BITS-1:0] y_end,
    output      logic [ITEM_BITS-1:0]  item
);

    logic signed [COORD_BITS:0]   dx;
    logic signed [COORD_BITS:0]   dy;
    logic        [COORD_BITS:0]   dx_abs;
    logic        [COORD_BITS:0]   dy_abs;
    logic        [COORD_BITS-1:0] ax;
    logic        [COORD_BITS-1:0] ay;
    logic signed [ERR_BITS-1:0]   ax2;
    logic signed [ERR_BITS-1:0]   ay2;
    logic signed [ERR_BITS-1:0]   err_init;
    logic signed [ERR_BITS-1:0]   inc_keep;
    logic signed [ERR_BITS-1:0]   inc_move;
    logic                         steep;
    logic                         minor_up;
    logic                         swap;
    logic                         is_start;
    logic        [COORD_BITS-1:0] start_x;
    logic        [COORD_BITS-1:0] start_y;
    logic        [COORD_BITS-1:0] major_end;

    always_comb begin
        dx       = $signed({1'b0, x_end}) - $signed({1'b0, x_begin});
        dy       = $signed({1'b0, y_end}) - $signed({1'b0, y_begin});
        dx_abs   = dx[COORD_BITS] ? (~dx + 1'b1) : dx;
        dy_abs   = dy[COORD_BITS] ? (~dy + 1'b1) : dy;
        ax       = dx_abs[COORD_BITS-1:0];
        ay       = dy_abs[COORD_BITS-1:0];
        ax2      = $signed({2'b00, ax, 1'b0});
        ay2      = $signed({2'b00, ay, 1'b0});
        steep    = ay > ax;
        // The minor axis counts up only when both deltas are nonzero and agree in sign.
        minor_up = (dx[COORD_BITS] && dy[COORD_BITS]) ||
                   (!dx[COORD_BITS] && (dx != '0) && !dy[COORD_BITS] && (dy != '0));

        if (steep) begin
            err_init  = ax2 - $signed({3'b000, ay});
            inc_keep  = ax2;
            inc_move  = ax2 - ay2;
            swap      = dy[COORD_BITS];
        end else begin
            err_init  = ay2 - $signed({3'b000, ax});
            inc_keep  = ay2;
            inc_move  = ay2 - ax2;
            swap      = dx[COORD_BITS];
        end

        if (swap) begin
            start_x   = x_end;
            start_y   = y_end;
            major_end = steep ? y_begin : x_begin;
        end else begin
            start_x   = x_begin;
            start_y   = y_begin;
            major_end = steep ? y_end : x_end;
        end

        is_start = (cmd == CMD_START);
        item     = {is_start, steep, minor_up, inc_move, inc_keep, err_init,
                    major_end, start_y, start_x};
    end

endmodule

`default_nettype wire

[hdl/lps_queue.sv]
// Two-entry queue that decouples the front end from the stepping back end.
`timescale 1ns / 1ps
`default_nettype none

module lps_queue
    import lps_pkg::*;
#(
    parameter int DATA_BITS = 8
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 wr_valid,
    output      logic                 wr_ready,
    input  wire logic [DATA_BITS-1:0] wr_data,
    output      logic                 rd_valid,
    input  wire logic                 rd_ready,
    output      logic [DATA_BITS-1:0] rd_data
);

    localparam int PTR_BITS = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_BITS = $clog2(QUEUE_DEPTH + 1);

    logic [DATA_BITS-1:0] entry_reg [QUEUE_DEPTH];
    logic [PTR_BITS-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_BITS-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_BITS-1:0]  count_reg, count_next;
    logic                 push;
    logic                 pop;

    assign wr_ready = (count_reg != CNT_BITS'(QUEUE_DEPTH));
    assign rd_valid = (count_reg != '0);
    assign rd_data  = entry_reg[rd_ptr_reg];
    assign push     = wr_valid && wr_ready;
    assign pop      = rd_valid && rd_ready;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        case ({push, pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

`default_nettype wire

[hdl/lps_back.sv]
// Back end: holds the line state, advances it one pixel per word, drives the output register.
`timescale 1ns / 1ps
`default_nettype none

module lps_back
    import lps_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF,
    localparam int ERR_BITS  = COORD_BITS + 3,
    localparam int ITEM_BITS = 3 * COORD_BITS + 3 * ERR_BITS + 3
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  q_valid,
    output      logic                  q_ready,
    input  wire logic [ITEM_BITS-1:0]  q_data,
    output      logic                  out_valid,
    input  wire logic                  out_ready,
    output      logic [COORD_BITS-1:0] out_x,
    output      logic [COORD_BITS-1:0] out_y,
    output      logic                  out_last
);

    logic                         in_start;
    logic                         in_steep;
    logic                         in_minor_up;
    logic signed [ERR_BITS-1:0]   in_inc_move;
    logic signed [ERR_BITS-1:0]   in_inc_keep;
    logic signed [ERR_BITS-1:0]   in_err;
    logic        [COORD_BITS-1:0] in_major_end;
    logic        [COORD_BITS-1:0] in_y;
    logic        [COORD_BITS-1:0] in_x;

    assign {in_start, in_steep, in_minor_up, in_inc_move, in_inc_keep, in_err,
            in_major_end, in_y, in_x} = q_data;

    logic [COORD_BITS-1:0]      cur_x_reg, cur_x_next;
    logic [COORD_BITS-1:0]      cur_y_reg, cur_y_next;
    logic [COORD_BITS-1:0]      major_end_reg, major_end_next;
    logic signed [ERR_BITS-1:0] err_reg, err_next;
    logic signed [ERR_BITS-1:0] inc_keep_reg, inc_keep_next;
    logic signed [ERR_BITS-1:0] inc_move_reg, inc_move_next;
    logic                       steep_reg, steep_next;
    logic                       minor_up_reg, minor_up_next;
    logic                       active_reg, active_next;
    logic                       out_valid_reg, out_valid_next;
    logic [COORD_BITS-1:0]      out_x_reg, out_x_next;
    logic [COORD_BITS-1:0]      out_y_reg, out_y_next;
    logic                       out_last_reg, out_last_next;

    logic                       pop;
    logic                       produce;
    logic                       move;
    logic                       fin;
    logic [COORD_BITS-1:0]      minor_delta;

    // A new word is taken whenever the output register is free or being drained.
    assign q_ready = !out_valid_reg || out_ready;
    assign pop     = q_valid && q_ready;

    always_comb begin
        cur_x_next     = cur_x_reg;
        cur_y_next     = cur_y_reg;
        major_end_next = major_end_reg;
        err_next       = err_reg;
        inc_keep_next  = inc_keep_reg;
        inc_move_next  = inc_move_reg;
        steep_next     = steep_reg;
        minor_up_next  = minor_up_reg;
        active_next    = active_reg;
        out_x_next     = out_x_reg;
        out_y_next     = out_y_reg;
        out_last_next  = out_last_reg;

        // Shallow lines step the minor axis on a nonnegative error, steep ones only on positive.
        move        = !err_reg[ERR_BITS-1] && (!steep_reg || (err_reg != '0));
        minor_delta = minor_up_reg ? COORD_BITS'(1) : '1;
        produce     = pop && (in_start || active_reg);

        if (in_start) begin
            cur_x_next     = in_x;
            cur_y_next     = in_y;
            major_end_next = in_major_end;
            err_next       = in_err;
            inc_keep_next  = in_inc_keep;
            inc_move_next  = in_inc_move;
            steep_next     = in_steep;
            minor_up_next  = in_minor_up;
        end else if (steep_reg) begin
            cur_y_next = cur_y_reg + 1'b1;
            cur_x_next = move ? cur_x_reg + minor_delta : cur_x_reg;
            err_next   = err_reg + (move ? inc_move_reg : inc_keep_reg);
        end else begin
            cur_x_next = cur_x_reg + 1'b1;
            cur_y_next = move ? cur_y_reg + minor_delta : cur_y_reg;
            err_next   = err_reg + (move ? inc_move_reg : inc_keep_reg);
        end

        fin = ((steep_next ? cur_y_next : cur_x_next) == major_end_next);

        if (produce) begin
            active_next   = !fin;
            out_x_next    = cur_x_next;
            out_y_next    = cur_y_next;
            out_last_next = fin;
        end

        if (pop) begin
            out_valid_next = produce;
        end else begin
            out_valid_next = out_valid_reg && !out_ready;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cur_x_reg     <= '0;
            cur_y_reg     <= '0;
            major_end_reg <= '0;
            err_reg       <= '0;
            inc_keep_reg  <= '0;
            inc_move_reg  <= '0;
            steep_reg     <= 1'b0;
            minor_up_reg  <= 1'b0;
            active_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (produce) begin
                cur_x_reg     <= cur_x_next;
                cur_y_reg     <= cur_y_next;
                major_end_reg <= major_end_next;
                err_reg       <= err_next;
                inc_keep_reg  <= inc_keep_next;
                inc_move_reg  <= inc_move_next;
                steep_reg     <= steep_next;
                minor_up_reg  <= minor_up_next;
            end
            active_reg    <= active_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_x_reg    <= out_x_next;
        out_y_reg    <= out_y_next;
        out_last_reg <= out_last_next;
    end

    assign out_valid = out_valid_reg;
    assign out_x     = out_x_reg;
    assign out_y     = out_y_reg;
    assign out_last  = out_last_reg;

endmodule

`default_nettype wire

[hdl/line_pixel_stepper.sv]
// Top level of the Bresenham line pixel stepper.
//
// Input words carry a command on s_tuser: start (load two endpoints from s_tdata and
// give the first pixel) or step (give the next pixel of the current line). A step word
// that arrives while no line is active is consumed and gives no output word.
// Each output word carries one pixel on m_tdata; m_tlast marks the final pixel.
//
// The front end computes the line setup in the accepting cycle and writes a two-entry
// queue; the back end pops one entry a cycle into its output register while that
// register is free or being drained. Throughput is one word per cycle, set by the pixel
// update in the back end, while m_tready stays high; each word passes the queue first.
//
// After reset no line is active, the queue is empty and m_tvalid is low.
// When the receiver holds m_tready low, the output word holds, the queue fills
// with up to two further words, and then s_tready drops until the output drains.
`timescale 1ns / 1ps
`default_nettype none

module line_pixel_stepper
    import lps_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF,
    localparam int S_DATA_BITS = ((4 * COORD_BITS + 7) / 8) * 8,
    localparam int M_DATA_BITS = ((2 * COORD_BITS + 7) / 8) * 8
) (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   s_tvalid,
    output      logic                   s_tready,
    // x_begin, y_begin, x_end, y_end, zero padding
    input  wire logic [S_DATA_BITS-1:0] s_tdata,
    // command
    input  wire logic                   s_tuser,
    output      logic                   m_tvalid,
    input  wire logic                   m_tready,
    // pixel_x, pixel_y, zero padding
    output      logic [M_DATA_BITS-1:0] m_tdata,
    output      logic                   m_tlast
);

    localparam int ERR_BITS  = COORD_BITS + 3;
    localparam int ITEM_BITS = 3 * COORD_BITS + 3 * ERR_BITS + 3;

    logic [ITEM_BITS-1:0]  front_item;
    logic                  q_valid;
    logic                  q_ready;
    logic [ITEM_BITS-1:0]  q_data;
    logic [COORD_BITS-1:0] pixel_x;
    logic [COORD_BITS-1:0] pixel_y;

    lps_front #(
        .COORD_BITS (COORD_BITS)
    ) u_front (
        .cmd     (s_tuser),
        .x_begin (s_tdata[COORD_BITS-1:0]),
        .y_begin (s_tdata[2*COORD_BITS-1:COORD_BITS]),
        .x_end   (s_tdata[3*COORD_BITS-1:2*COORD_BITS]),
        .y_end   (s_tdata[4*COORD_BITS-1:3*COORD_BITS]),
        .item    (front_item)
    );

    lps_queue #(
        .DATA_BITS (ITEM_BITS)
    ) u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_valid (s_tvalid),
        .wr_ready (s_tready),
        .wr_data  (front_item),
        .rd_valid (q_valid),
        .rd_ready (q_ready),
        .rd_data  (q_data)
    );

    lps_back #(
        .COORD_BITS (COORD_BITS)
    ) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .q_valid   (q_valid),
        .q_ready   (q_ready),
        .q_data    (q_data),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_x     (pixel_x),
        .out_y     (pixel_y),
        .out_last  (m_tlast)
    );

    assign m_tdata = M_DATA_BITS'({pixel_y, pixel_x});

endmodule

`default_nettype wire

[dv/line_pixel_stepper_test.sv]
// Testbench for the Bresenham line pixel stepper: line stimulus and a scoreboard that predicts pixels.
`timescale 1ns / 1ps

module line_pixel_stepper_test;
    import lps_pkg::*;

    localparam int CB = COORD_BITS_DEF;
    localparam int SB = ((4 * CB + 7) / 8) * 8;
    localparam int MB = ((2 * CB + 7) / 8) * 8;
    localparam int MAXC = (1 << CB) - 1;
    localparam int RANDOM_PIXELS = 400;
    localparam int LONG_HOLD = 150;

    logic          aclk     = 1'b0;
    logic          aresetn  = 1'b0;
    logic          s_tvalid = 1'b0;
    logic          s_tready;
    logic [SB-1:0] s_tdata  = '0;
    logic          s_tuser  = CMD_START;
    logic          m_tvalid;
    logic          m_tready = 1'b0;
    logic [MB-1:0] m_tdata;
    logic          m_tlast;

    line_pixel_stepper #(.COORD_BITS(CB)) dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    // Tracks the line being drawn and holds the pixels still owed by the block.
    class line_pixel_board;
        typedef struct packed {
            logic [CB-1:0] x;
            logic [CB-1:0] y;
            logic          last;
        } pixel_t;

        pixel_t            owed_pixels[$];
        logic [CB-1:0]     cur_x, cur_y, major_end, span_x, span_y;
        logic signed [CB+2:0] error_term;
        logic              steep, minor_up, active;
        int                errors;

        function new();
            cur_x = '0; cur_y = '0; major_end = '0; span_x = '0; span_y = '0;
            error_term = '0; steep = 1'b0; minor_up = 1'b0; active = 1'b0;
            errors = 0;
        endfunction

        function int pending();
            return owed_pixels.size();
        endfunction

        function void owe_pixel();
            pixel_t p;
            p.x = cur_x;
            p.y = cur_y;
            p.last = ((steep ? cur_y : cur_x) == major_end);
            owed_pixels.push_back(p);
            if (p.last) begin
                active = 1'b0;
            end
        endfunction

        function void note_word(logic cmd, logic [SB-1:0] data);
            int xb, yb, xe, ye, dx, dy, ax, ay, err, sx, sy;
            if (cmd == CMD_START) begin
                xb = data[CB-1:0];
                yb = data[2*CB-1:CB];
                xe = data[3*CB-1:2*CB];
                ye = data[4*CB-1:3*CB];
                dx = xe - xb;
                dy = ye - yb;
                ax = (dx < 0) ? -dx : dx;
                ay = (dy < 0) ? -dy : dy;
                span_x = ax;
                span_y = ay;
                minor_up = (dx < 0 && dy < 0) || (dx > 0 && dy > 0);
                steep = (ay > ax);
                // Swap the endpoints so the major coordinate always counts up.
                if (!steep) begin
                    err = 2 * ay - ax;
                    if (dx >= 0) begin
                        cur_x = xb; cur_y = yb; major_end = xe;
                    end else begin
                        cur_x = xe; cur_y = ye; major_end = xb;
                    end
                end else begin
                    err = 2 * ax - ay;
                    if (dy >= 0) begin
                        cur_x = xb; cur_y = yb; major_end = ye;
                    end else begin
                        cur_x = xe; cur_y = ye; major_end = yb;
                    end
                end
                error_term = err;
                active = 1'b1;
                owe_pixel();
            end else if (active) begin
                err = error_term;
                sx = span_x;
                sy = span_y;
                // The shallow case steps the minor axis on err >= 0, the steep one on err > 0.
                if (!steep) begin
                    cur_x = cur_x + 1'b1;
                    if (err < 0) begin
                        err = err + 2 * sy;
                    end else begin
                        cur_y = minor_up ? cur_y + 1'b1 : cur_y - 1'b1;
                        err = err + 2 * (sy - sx);
                    end
                end else begin
                    cur_y = cur_y + 1'b1;
                    if (err <= 0) begin
                        err = err + 2 * sx;
                    end else begin
                        cur_x = minor_up ? cur_x + 1'b1 : cur_x - 1'b1;
                        err = err + 2 * (sx - sy);
                    end
                end
                error_term = err;
                owe_pixel();
            end
        endfunction

        function void check_pixel(logic [CB-1:0] x, logic [CB-1:0] y, logic last);
            pixel_t p;
            if (owed_pixels.size() == 0) begin
                $display("%0t: unexpected word x=%0d y=%0d last=%0b", $time, x, y, last);
                errors++;
                return;
            end
            p = owed_pixels.pop_front();
            if (x !== p.x) begin
                $display("%0t: pixel_x expected %0d actual %0d", $time, p.x, x);
                errors++;
            end
            if (y !== p.y) begin
                $display("%0t: pixel_y expected %0d actual %0d", $time, p.y, y);
                errors++;
            end
            if (last !== p.last) begin
                $display("%0t: last expected %0b actual %0b", $time, p.last, last);
                errors++;
            end
        endfunction
    endclass

    line_pixel_board board;
    int burst_left = 0;
    int pixels_left = 0;
    int pixels_driven = 0;
    bit hold_req = 1'b0;

    initial begin
        forever #5 aclk = ~aclk;
    end

    initial begin
        #5_000_000;
        $display("*** FAILED ***");
        $finish;
    end

    // Monitor: both channels are sampled at the rising edge.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                board.check_pixel(m_tdata[CB-1:0], m_tdata[2*CB-1:CB], m_tlast);
            end
            if (s_tvalid && s_tready) begin
                board.note_word(s_tuser, s_tdata);
            end
        end
    end

    // Receiver: segments of different stall patterns, plus a long hold-off on request.
    initial begin
        int mode, len;
        forever begin
            mode = $urandom_range(0, 3);
            len = $urandom_range(10, 60);
            for (int i = 0; i < len; i++) begin
                if (hold_req) begin
                    for (int h = 0; h < LONG_HOLD; h++) begin
                        @(negedge aclk);
                        m_tready <= 1'b0;
                    end
                    hold_req = 1'b0;
                end
                @(negedge aclk);
                case (mode)
                    0: m_tready <= 1'b1;
                    1: m_tready <= $urandom_range(0, 1);
                    2: m_tready <= ($urandom_range(0, 3) == 0);
                    default: m_tready <= (i % 3 != 0);
                endcase
            end
        end
    end

    // Offers one word, with a random gap first when the current burst is used up.
    task automatic send_word(logic cmd, logic [SB-1:0] data);
        int gap;
        if (burst_left == 0 && !hold_req) begin
            gap = $urandom_range(1, 6);
            @(negedge aclk);
            s_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge aclk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 60)
                                                     : $urandom_range(1, 8);
        end
        if (burst_left > 0) begin
            burst_left--;
        end
        @(negedge aclk);
        s_tvalid <= 1'b1;
        s_tuser <= cmd;
        s_tdata <= data;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    task automatic start_line(int xb, int yb, int xe, int ye);
        int ax, ay;
        ax = (xe > xb) ? xe - xb : xb - xe;
        ay = (ye > yb) ? ye - yb : yb - ye;
        pixels_left = (ax > ay) ? ax : ay;
        pixels_driven++;
        send_word(CMD_START, {ye[CB-1:0], xe[CB-1:0], yb[CB-1:0], xb[CB-1:0]});
    endtask

    // Step words carry random data, which the block must ignore.
    task automatic send_step();
        logic [63:0] junk;
        junk = {$urandom, $urandom};
        if (pixels_left > 0) begin
            pixels_left--;
            pixels_driven++;
        end
        send_word(CMD_STEP, junk[SB-1:0]);
    endtask

    task automatic draw(int xb, int yb, int xe, int ye, int steps);
        start_line(xb, yb, xe, ye);
        repeat (steps) send_step();
    endtask

    task automatic wait_drained();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (board.pending() != 0) @(posedge aclk);
    endtask

    function automatic int near(int c, int reach);
        int lo, hi;
        lo = (c - reach < 0) ? 0 : c - reach;
        hi = (c + reach > MAXC) ? MAXC : c + reach;
        return $urandom_range(lo, hi);
    endfunction

    initial begin
        int xb, yb, xe, ye, reach, steps, pick;
        bit held, drained;
        board = new();
        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Directed part.
        send_step();                          // no line yet
        draw(0, 0, 0, 0, 1);                  // single point, then a step that is dropped
        draw(MAXC, MAXC, MAXC, MAXC, 0);
        draw(0, 0, MAXC, MAXC, 2);            // equal spans: x is the major axis
        draw(MAXC, 0, 0, MAXC, 2);            // restarted while active, minor goes down
        draw(10, 20, 14, 21, 5);              // shallow, one extra step after the end
        draw(13, 21, 10, 20, 3);              // both deltas negative
        draw(100, 200, 101, 197, 3);          // steep with the minor axis going down
        draw(5, 5, 5, 7, 2);                  // vertical
        wait_drained();

        // Random part: mostly complete lines, some cut short, some noise.
        held = 1'b0;
        drained = 1'b0;
        while (pixels_driven < RANDOM_PIXELS + 25) begin
            if (!held && pixels_driven > 120) begin
                hold_req = 1'b1;
                held = 1'b1;
            end
            if (!drained && pixels_driven > 260) begin
                wait_drained();
                drained = 1'b1;
            end
            pick = $urandom_range(0, 99);
            if (pick < 80) begin
                reach = ($urandom_range(0, 19) == 0) ? $urandom_range(13, 200)
                                                     : $urandom_range(0, 12);
                xb = $urandom_range(0, MAXC);
                yb = $urandom_range(0, MAXC);
                xe = near(xb, reach);
                ye = near(yb, reach);
                start_line(xb, yb, xe, ye);
                steps = pixels_left;
                if ($urandom_range(0, 6) == 0) begin
                    steps = $urandom_range(0, steps);
                end else if ($urandom_range(0, 6) == 0) begin
                    steps = steps + $urandom_range(1, 2);
                end
                repeat (steps) send_step();
            end else if (pick < 90) begin
                send_step();
            end else begin
                start_line($urandom_range(0, MAXC), $urandom_range(0, MAXC),
                           $urandom_range(0, MAXC), $urandom_range(0, MAXC));
                repeat ($urandom_range(0, 4)) send_step();
            end
        end

        wait_drained();
        repeat (10) @(posedge aclk);
        if (board.errors == 0 && board.pending() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
